// File: hdl/rao_pkg.sv
// Shared types, constants and the divide-by-100 helper for the ramped analog output unit.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package rao_pkg;

  localparam int LVL_W     = 15;
  localparam int DUTY_W    = 8;
  localparam int ACC_W     = 24;
  localparam int AVG_EXTRA = 8;
  localparam int TICKS_W   = 32;
  localparam int CFG_IDX_W = 2;

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [DUTY_W-1:0] duty_t;

  localparam lvl_t  MAX_LEVEL_RST = LVL_W'(25600);
  localparam duty_t DUTY_MAX      = DUTY_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEVEL   = 2'd0,
    CFG_MAX_LEVEL   = 2'd1,
    CFG_RAMP_ENABLE = 2'd2,
    CFG_RAMP_STEP   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    lvl_t min_level;
    lvl_t max_level;
    logic ramp_enable;
    lvl_t ramp_step;
  } cfg_t;

  // one captured input beat; the three interlocks are merged on capture
  typedef struct packed {
    logic active_write;
    logic active_value;
    logic lock;
    lvl_t setpoint;
    logic tick;
  } item_t;

  // level stage result, also the channel state (level, active flag)
  typedef struct packed {
    lvl_t               level;
    logic               act;
    logic               lock;
    logic               upd;
    logic [TICKS_W-1:0] on_ticks;
  } lvl_st_t;

  typedef struct packed {
    logic               locked;
    logic               is_active;
    logic [TICKS_W-1:0] on_ticks;
    lvl_t               mean_level;
    lvl_t               level;
    duty_t              duty;
  } res_t;

  // floor(x / 100) for any 32-bit x: reciprocal multiply, exact over the full range
  function automatic logic [31:0] div100(input logic [31:0] x);
    logic [63:0] p;
    p = {32'd0, x} * 64'd1374389535;
    return 32'(p >> 37);
  endfunction

endpackage

// File: hdl/rao_level.sv
// Level stage: active flag, interlock, setpoint clamp, ramp and active-tick counter.
// Depends on rao_pkg. Its output register doubles as the channel state.
`timescale 1ns / 1ps

module rao_level #(
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rao_pkg::cfg_t    cfg_i,
  input  logic             item_vld_i,
  input  rao_pkg::item_t   item_i,
  input  logic             adv_i,
  output logic             rdy_o,
  output logic             vld_o,
  output rao_pkg::lvl_st_t st_o
);
  import rao_pkg::*;

  localparam lvl_t FRAC_MASK = LVL_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic                   vld_r, vld_nxt;
  lvl_st_t                st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   fire;
  logic                   act_req, act_nxt;
  lvl_t                   capped, clamped, target, down_diff, level_nxt;
  logic [LVL_W:0]         up_sum;

  assign rdy_o = !vld_r || adv_i;
  assign fire  = item_vld_i && rdy_o;

  always_comb begin
    act_req = item_i.active_write ? item_i.active_value : st_r.act;
    act_nxt = act_req && !item_i.lock;

    // lower bound applied last, so min above max gives min
    capped  = (item_i.setpoint < cfg_i.max_level) ? item_i.setpoint : cfg_i.max_level;
    clamped = (capped > cfg_i.min_level) ? capped : cfg_i.min_level;
    target  = clamped & ~FRAC_MASK;

    up_sum    = {1'b0, st_r.level} + {1'b0, cfg_i.ramp_step};
    down_diff = st_r.level - target;

    level_nxt = st_r.level;
    if (!act_nxt) begin
      level_nxt = cfg_i.min_level;
    end else if (!cfg_i.ramp_enable) begin
      level_nxt = clamped;
    end else if (item_i.tick) begin
      if (target > st_r.level) begin
        level_nxt = (up_sum < {1'b0, target}) ? LVL_W'(up_sum) : target;
      end else if (target < st_r.level) begin
        level_nxt = (down_diff <= cfg_i.ramp_step) ? target : st_r.level - cfg_i.ramp_step;
      end
    end

    count_nxt = (act_nxt && item_i.tick) ? count_r + COUNT_WIDTH'(1) : count_r;

    st_nxt.level    = level_nxt;
    st_nxt.act      = act_nxt;
    st_nxt.lock     = item_i.lock;
    st_nxt.upd      = act_nxt && item_i.tick;
    st_nxt.on_ticks = TICKS_W'(count_nxt);

    vld_nxt = rdy_o ? item_vld_i : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      st_r    <= '0;
      count_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (fire) begin
        st_r    <= st_nxt;
        count_r <= count_nxt;
      end
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;

  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !act_nxt |=> st_r.level == $past(cfg_i.min_level))
    else $error("inactive step did not return level to min_level");

  a_lock_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_i.lock |=> !st_r.act && st_r.lock)
    else $error("interlock did not force the channel inactive");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !(act_nxt && item_i.tick) |=> count_r == $past(count_r))
    else $error("tick counter moved without an active tick");

endmodule

// File: hdl/rao_avg.sv
// Output stage: 99/100 exponential average, duty conversion and the result register.
// Depends on rao_pkg.
`timescale 1ns / 1ps

module rao_avg #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             st_vld_i,
  input  rao_pkg::lvl_st_t st_i,
  input  logic             adv_i,
  output logic             rdy_o,
  output logic             vld_o,
  output rao_pkg::res_t    res_o
);
  import rao_pkg::*;

  logic               vld_r, vld_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  res_t               res_r, res_nxt;
  logic               fire;
  logic [31:0]        acc_ext, avg_sum, lvl_ext, duty_prod, duty_q;
  duty_t              duty_sat;

  assign rdy_o = !vld_r || adv_i;
  assign fire  = st_vld_i && rdy_o;

  always_comb begin
    acc_ext = 32'(acc_r);
    lvl_ext = 32'(st_i.level);
    // acc * 99 as acc * 100 - acc, then add the new level with the extra fraction bits
    avg_sum = (acc_ext << 6) + (acc_ext << 5) + (acc_ext << 2) - acc_ext
            + (lvl_ext << AVG_EXTRA);
    acc_nxt = st_i.upd ? ACC_W'(div100(avg_sum)) : acc_r;

    // duty = floor(level * 255 / (100 << FRAC_BITS))
    duty_prod = ((lvl_ext << 8) - lvl_ext) >> FRAC_BITS;
    duty_q    = div100(duty_prod);
    duty_sat  = (duty_q > 32'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(duty_q);

    res_nxt.duty       = st_i.act ? duty_sat : '0;
    res_nxt.level      = st_i.act ? st_i.level : '0;
    res_nxt.mean_level = acc_nxt[AVG_EXTRA +: LVL_W];
    res_nxt.on_ticks   = st_i.on_ticks;
    res_nxt.is_active  = st_i.act;
    res_nxt.locked     = st_i.lock;

    vld_nxt = rdy_o ? st_vld_i : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      acc_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (fire) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !st_i.upd |=> acc_r == $past(acc_r))
    else $error("average moved without an active tick");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !res_r.is_active |-> res_r.duty == '0 && res_r.level == '0)
    else $error("inactive result shows nonzero duty or level");

  a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && st_i.level == '0 |=> res_r.duty == '0)
    else $error("zero level gave nonzero duty");

endmodule

// File: hdl/ramped_analog_output_unit.sv
// Top level of the ramped analog output unit: config registers, input register,
// level stage (rao_level) and average/output stage (rao_avg). Depends on rao_pkg.
//
//   channel | dir | tdata / fields
//   in_     | in  | 24 bit: active_write, active_value, lock_a/b/c, setpoint, tick
//   out_    | out | 72 bit: duty, level, mean_level, on_ticks, is_active, locked
//   cfg_    | in  | we, 2-bit register index, 15-bit data; write-only
//
// One beat per cycle unless out_ stalls; beats pass input, level and output registers.
// The clamp/ramp compare chain sets the level stage; the divide-by-100 reciprocal
// multiply sets the output stage.
// Reset is synchronous on rst_n; it clears all but the input and result data registers.
// Each of the three stage registers advances when the stage after it is empty or moving.
`timescale 1ns / 1ps

module ramped_analog_output_unit #(
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] active_write, [1] active_value, [2] lock_a, [3] lock_b, [4] lock_c,
  // [19:5] setpoint, [20] tick, [23:21] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] duty, [22:8] level, [37:23] mean_level, [69:38] on_ticks,
  // [70] is_active, [71] locked
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);
  import rao_pkg::*;

  cfg_t    cfg_r;
  logic    in_vld_r, in_vld_nxt;
  item_t   in_item_r, in_item;
  logic    lvl_rdy, lvl_vld, avg_rdy;
  lvl_st_t lvl_st;
  res_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_level   <= '0;
      cfg_r.max_level   <= MAX_LEVEL_RST;
      cfg_r.ramp_enable <= 1'b0;
      cfg_r.ramp_step   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MIN_LEVEL:   cfg_r.min_level   <= cfg_wdata;
        CFG_MAX_LEVEL:   cfg_r.max_level   <= cfg_wdata;
        CFG_RAMP_ENABLE: cfg_r.ramp_enable <= cfg_wdata[0];
        CFG_RAMP_STEP:   cfg_r.ramp_step   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.active_write = in_tdata[0];
    in_item.active_value = in_tdata[1];
    in_item.lock         = |in_tdata[4:2];
    in_item.setpoint     = in_tdata[19:5];
    in_item.tick         = in_tdata[20];
  end

  assign in_tready  = !in_vld_r || lvl_rdy;
  assign in_vld_nxt = in_tready ? in_tvalid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item;
    end
  end

  rao_level #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .item_vld_i (in_vld_r),
    .item_i     (in_item_r),
    .adv_i      (avg_rdy),
    .rdy_o      (lvl_rdy),
    .vld_o      (lvl_vld),
    .st_o       (lvl_st)
  );

  rao_avg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .st_vld_i (lvl_vld),
    .st_i     (lvl_st),
    .adv_i    (out_tready),
    .rdy_o    (avg_rdy),
    .vld_o    (out_tvalid),
    .res_o    (res)
  );

  assign out_tdata = {res.locked, res.is_active, res.on_ticks,
                      res.mean_level, res.level, res.duty};

endmodule
